FILE: sv/lsq_pkg.sv
// Package for the largest ones square finder.
// Holds field widths, reset values and the flag word that travels with each pixel.
// No dependencies.
`default_nettype none

package lsq_pkg;

  localparam int CFG_W  = 10;
  localparam int SIDE_W = 10;
  localparam int AREA_W = 19;

  typedef logic [CFG_W-1:0]  cfg_t;
  typedef logic [SIDE_W-1:0] side_t;
  typedef logic [AREA_W-1:0] area_t;

  localparam cfg_t  ROW_WIDTH_RST = 10'd512;
  localparam side_t SIDE_MAX      = '1;
  localparam logic  PIXEL_SET     = 1'b1;

  // Per-pixel flags passed from the front to the back through the queue
  typedef struct packed {
    logic pixel_bit;
    logic last_of_frame;
    logic first_row;
  } pix_flags_t;

endpackage

`default_nettype wire

FILE: sv/lsq_in_if.sv
// Pixel input channel: valid/ready handshake with one pixel and its frame-end flag.
// No dependencies.
`default_nettype none

interface lsq_in_if;
  logic valid;
  logic ready;
  logic pixel_bit;
  logic last_of_frame;

  modport source (output valid, output pixel_bit, output last_of_frame, input ready);
  modport sink   (input valid, input pixel_bit, input last_of_frame, output ready);
endinterface

`default_nettype wire

FILE: sv/lsq_out_if.sv
// Result channel: valid/ready handshake carrying the largest side and its area.
// Depends on lsq_pkg for the field widths.
`default_nettype none

interface lsq_out_if;
  import lsq_pkg::*;

  logic  valid;
  logic  ready;
  side_t max_side;
  area_t max_area;

  modport source (output valid, output max_side, output max_area, input ready);
  modport sink   (input valid, input max_side, input max_area, output ready);
endinterface

`default_nettype wire

FILE: sv/lsq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module lsq_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 512
) (
  input  wire logic                                clk,
  input  wire logic                                we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                    wdata,
  input  wire logic                                re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                    rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: sv/lsq_front.sv
// Front end: accepts pixels, tracks column and first-row state, tags each word.
// Depends on lsq_pkg and lsq_in_if.
`default_nettype none

module lsq_front #(
  parameter int MAX_WIDTH = 512,
  parameter int COL_W     = 9
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  lsq_in_if.sink                  in_ch,
  input  wire lsq_pkg::cfg_t      row_width,
  input  wire logic               q_full,
  output logic                    q_push,
  output lsq_pkg::pix_flags_t     q_flags,
  output logic      [COL_W-1:0]   q_col
);
  import lsq_pkg::*;

  localparam int CMP_W = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;
  localparam logic [CMP_W-1:0] MAXW = CMP_W'(MAX_WIDTH);

  logic [COL_W-1:0] col_r, col_nxt;
  logic             first_r, first_nxt;
  logic [CMP_W-1:0] wide, eff_w, cnt_next;
  logic             row_end;
  logic             accept;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    wide     = CMP_W'(row_width);
    // zero acts as one, oversize clamps to the buffer length
    if (wide == '0) begin
      eff_w = CMP_W'(1);
    end else if (wide > MAXW) begin
      eff_w = MAXW;
    end else begin
      eff_w = wide;
    end
    cnt_next = CMP_W'(col_r) + CMP_W'(1);
    row_end  = (cnt_next >= eff_w);

    col_nxt   = col_r;
    first_nxt = first_r;
    if (accept) begin
      if (in_ch.last_of_frame) begin
        col_nxt   = '0;
        first_nxt = 1'b1;
      end else if (row_end) begin
        col_nxt   = '0;
        first_nxt = 1'b0;
      end else begin
        col_nxt   = cnt_next[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      first_r <= 1'b1;
    end else begin
      col_r   <= col_nxt;
      first_r <= first_nxt;
    end
  end

  assign q_push                = accept;
  assign q_flags.pixel_bit     = in_ch.pixel_bit;
  assign q_flags.last_of_frame = in_ch.last_of_frame;
  assign q_flags.first_row     = first_r;
  assign q_col                 = col_r;

  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.last_of_frame) |=> (col_r == '0 && first_r))
    else $error("front did not restart after frame end");

endmodule

`default_nettype wire

FILE: sv/lsq_fifo.sv
// Short queue between front and back so each side can stall on its own.
// No dependencies.
`default_nettype none

module lsq_fifo #(
  parameter int WIDTH = 12
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] head_data,
  output logic                  not_empty,
  output logic                  full
);

  localparam int DEPTH = 4;
  localparam int PTR_W = 2;
  localparam int CNT_W = 3;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r, count_nxt;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign head_data = mem_r[rd_ptr_r];
  assign not_empty = (count_r != '0);
  assign full      = (count_r == CNT_W'(DEPTH));

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (full && !pop) |=> (count_r == CNT_W'(DEPTH)))
    else $error("queue count moved past full");

endmodule

`default_nettype wire

FILE: sv/lsq_back.sv
// Back end: reads the line buffer, computes each pixel's square side, tracks the best.
// Depends on lsq_pkg, lsq_out_if and lsq_ram.
`default_nettype none

module lsq_back #(
  parameter int MAX_WIDTH = 512,
  parameter int COL_W     = 9
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                q_valid,
  input  wire lsq_pkg::pix_flags_t q_flags,
  input  wire logic    [COL_W-1:0] q_col,
  output logic                     q_pop,
  lsq_out_if.source                out_ch
);
  import lsq_pkg::*;

  pix_flags_t       b2_flags_r;
  logic [COL_W-1:0] b2_col_r;
  logic             b2_valid_r, b2_valid_nxt;
  logic             byp_hit_r, byp_hit_nxt;
  side_t            byp_data_r;
  side_t            left_r, upleft_r, best_r;
  logic             out_valid_r, out_valid_nxt;
  side_t            out_side_r;

  side_t             ram_rdata;
  logic              ram_we;
  logic              b2_last, b2_retire, col_zero;
  side_t             up, upleft, left, m, side, best_upd;
  logic [SIDE_W:0]   sum;
  logic [2*SIDE_W-1:0] sq;

  assign b2_last   = b2_flags_r.last_of_frame;
  assign b2_retire = b2_valid_r && (!b2_last || !out_valid_r || out_ch.ready);
  assign q_pop     = q_valid && (!b2_valid_r || b2_retire);
  assign ram_we    = b2_retire;

  lsq_ram #(
    .WIDTH (SIDE_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (b2_col_r),
    .wdata (side),
    .re    (q_pop),
    .raddr (q_col),
    .rdata (ram_rdata)
  );

  always_comb begin
    col_zero = (b2_col_r == '0);
    // take the word being written when the read hit the same column
    up     = b2_flags_r.first_row ? '0 : (byp_hit_r ? byp_data_r : ram_rdata);
    upleft = (b2_flags_r.first_row || col_zero) ? '0 : upleft_r;
    left   = col_zero ? '0 : left_r;

    m = (left < up) ? left : up;
    m = (m < upleft) ? m : upleft;
    sum = {1'b0, m} + (SIDE_W + 1)'(1);
    if (b2_flags_r.pixel_bit == PIXEL_SET) begin
      side = sum[SIDE_W] ? SIDE_MAX : sum[SIDE_W-1:0];
    end else begin
      side = '0;
    end
    best_upd = (side > best_r) ? side : best_r;

    byp_hit_nxt  = q_pop && ram_we && (q_col == b2_col_r);
    b2_valid_nxt = q_pop ? 1'b1 : (b2_retire ? 1'b0 : b2_valid_r);

    out_valid_nxt = out_valid_r;
    if (b2_retire && b2_last) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b2_valid_r  <= 1'b0;
      byp_hit_r   <= 1'b0;
      out_valid_r <= 1'b0;
      left_r      <= '0;
      upleft_r    <= '0;
      best_r      <= '0;
    end else begin
      b2_valid_r  <= b2_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (q_pop) begin
        byp_hit_r <= byp_hit_nxt;
      end
      if (b2_retire) begin
        left_r   <= side;
        upleft_r <= up;
        best_r   <= b2_last ? '0 : best_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      b2_flags_r <= q_flags;
      b2_col_r   <= q_col;
      byp_data_r <= side;
    end
    if (b2_retire && b2_last) begin
      out_side_r <= best_upd;
    end
  end

  assign sq              = out_side_r * out_side_r;
  assign out_ch.valid    = out_valid_r;
  assign out_ch.max_side = out_side_r;
  assign out_ch.max_area = sq[AREA_W-1:0];

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (b2_valid_r && b2_last && out_valid_r && !out_ch.ready) |-> (!q_pop && !ram_we))
    else $error("back advanced while result was stalled");

  a_best_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (b2_retire && b2_last) |=> (best_r == '0 && out_valid_r))
    else $error("frame end did not post result and clear best side");

endmodule

`default_nettype wire

FILE: sv/largest_ones_square_finder.sv
// Largest all-ones square finder: one pixel per cycle if unstalled, through a line buffer.
// A frame's last pixel goes through the queue and the back end's stage before out_ch.valid.
// Throughput: one pixel per cycle if unstalled, one line-buffer read and write per pixel.
// A stalled result holds the back end only when another frame end reaches it.
// Reset: row_width goes to 512, frame state clears; the line buffer is not cleared.
// Depends on lsq_pkg, lsq_in_if, lsq_out_if, lsq_front, lsq_fifo, lsq_back, lsq_ram.
`default_nettype none

module largest_ones_square_finder #(
  parameter int MAX_WIDTH = 512
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  lsq_in_if.sink             in_ch,
  lsq_out_if.source          out_ch,
  input  wire logic          cfg_we,
  input  wire lsq_pkg::cfg_t cfg_wdata
);
  import lsq_pkg::*;

  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int Q_W   = $bits(pix_flags_t) + COL_W;

  cfg_t             row_width_r;
  logic             q_push, q_pop, q_full, q_not_empty;
  pix_flags_t       f_flags, b_flags;
  logic [COL_W-1:0] f_col, b_col;
  logic [Q_W-1:0]   q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r <= ROW_WIDTH_RST;
    end else if (cfg_we) begin
      row_width_r <= cfg_wdata;
    end
  end

  lsq_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .COL_W     (COL_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .row_width (row_width_r),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_flags   (f_flags),
    .q_col     (f_col)
  );

  lsq_fifo #(
    .WIDTH (Q_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data ({f_flags, f_col}),
    .pop       (q_pop),
    .head_data (q_head),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  assign b_flags = q_head[Q_W-1:COL_W];
  assign b_col   = q_head[COL_W-1:0];

  lsq_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .COL_W     (COL_W)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_not_empty),
    .q_flags (b_flags),
    .q_col   (b_col),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire

FILE: dv/tb.sv
// Self-checking bench for largest_ones_square_finder: streams binary frames through
// the pixel channel and checks each frame's largest square against a local predictor.
// Depends on lsq_pkg, lsq_in_if, lsq_out_if and the finder RTL.
`timescale 1ns / 100ps

module tb;
  import lsq_pkg::*;

  localparam int MAX_WIDTH   = 512;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int SETTLE      = 8;    // cycles after the last result
  localparam int LONG_HOLD   = 300;

  typedef struct packed {
    side_t side;
    area_t area;
  } square_t;

  // Tracks the square sides of the current frame and holds the squares still owed.
  class square_scoreboard;
    cfg_t        row_width;
    side_t       line_sides[MAX_WIDTH];
    int unsigned col_count;
    side_t       left_side;
    side_t       upleft_side;
    side_t       best_side;
    bit          first_row;
    square_t     owed_squares[$];
    int unsigned errors;
    int unsigned squares_seen;
    int unsigned biggest_side;

    function new();
      row_width = ROW_WIDTH_RST;
      foreach (line_sides[i]) line_sides[i] = '0;
      errors = 0;
      squares_seen = 0;
      biggest_side = 0;
      restart_frame();
    endfunction

    function void restart_frame();
      col_count = 0;
      left_side = '0;
      upleft_side = '0;
      best_side = '0;
      first_row = 1'b1;
    endfunction

    function void set_width(cfg_t w);
      row_width = w;
    endfunction

    function int unsigned pending();
      return owed_squares.size();
    endfunction

    function void note_pixel(logic pix, logic last);
      int unsigned w, col, up, ul, lf, m;
      side_t   side;
      square_t sq;
      w = (row_width == 0) ? 1 : ((row_width > MAX_WIDTH) ? MAX_WIDTH : row_width);
      col = (col_count >= MAX_WIDTH) ? 0 : col_count;
      up = first_row ? 0 : line_sides[col];
      ul = (first_row || col == 0) ? 0 : upleft_side;
      lf = (col == 0) ? 0 : left_side;
      if (pix == PIXEL_SET) begin
        m = (lf < up) ? lf : up;
        if (ul < m) m = ul;
        side = (m + 1 > SIDE_MAX) ? SIDE_MAX : side_t'(m + 1);
      end else begin
        side = '0;
      end
      if (side > best_side) best_side = side;
      line_sides[col] = side;
      upleft_side = side_t'(up);
      left_side = side;
      col++;
      // end of row: next pixel starts at column zero with no left neighbors
      if (col >= w) begin
        col = 0;
        first_row = 1'b0;
        left_side = '0;
        upleft_side = '0;
      end
      col_count = col;
      if (last) begin
        sq.side = best_side;
        sq.area = area_t'(int'(best_side) * int'(best_side));
        owed_squares.push_back(sq);
        if (best_side > biggest_side) biggest_side = best_side;
        restart_frame();
      end
    endfunction

    function void check_result(side_t s, area_t a);
      square_t sq;
      squares_seen++;
      if (owed_squares.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word side %0d area %0d", $time, s, a);
      end else begin
        sq = owed_squares.pop_front();
        if (s !== sq.side) begin
          errors++;
          $display("%0t: max_side expected %0d, got %0d", $time, sq.side, s);
        end
        if (a !== sq.area) begin
          errors++;
          $display("%0t: max_area expected %0d, got %0d", $time, sq.area, a);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  cfg_t cfg_wdata;

  lsq_in_if  in_ch();
  lsq_out_if out_ch();

  largest_ones_square_finder #(.MAX_WIDTH(MAX_WIDTH)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  square_scoreboard sb;
  bit          gaps_on;
  bit          hold_request;
  int unsigned stall_left;
  int unsigned cycle_count;
  int unsigned pixels_sent;
  int unsigned frames_sent;
  int unsigned width_writes;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results owed", cycle_count, sb.pending());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result side: long hold on request, otherwise random stalls.
  always @(negedge clk) begin
    int unsigned g;
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (hold_request) begin
      out_ch.ready <= 1'b0;
      stall_left <= LONG_HOLD - 1;
      hold_request <= 1'b0;
    end else begin
      g = pick_gap();
      out_ch.ready <= (g == 0);
      if (g > 0) stall_left <= g - 1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.max_side, out_ch.max_area);
  end

  task automatic send_pixel(logic pix, logic last);
    int unsigned g;
    g = pick_gap();
    @(negedge clk);
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.pixel_bit <= pix;
    in_ch.last_of_frame <= last;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_pixel(pix, last);
    pixels_sent++;
    if (last) frames_sent++;
  endtask

  // Send a frame of rows full rows plus tail pixels, each set with pct percent chance.
  task automatic send_frame(int unsigned w_eff, int unsigned rows, int unsigned tail,
                            int unsigned pct);
    int unsigned total;
    total = w_eff * rows + tail;
    for (int unsigned i = 0; i < total; i++)
      send_pixel($urandom_range(0, 99) < pct, i == total - 1);
  endtask

  // Bits go out MSB first; the last one closes the frame.
  task automatic send_pattern(logic [15:0] bits, int unsigned n);
    for (int unsigned i = 0; i < n; i++)
      send_pixel(bits[n - 1 - i], i == n - 1);
  endtask

  // Hold off the sender until every owed square has come back, then let the pipe settle.
  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_width(cfg_t w);
    drain();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= w;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_width(w);
    width_writes++;
  endtask

  initial begin
    int unsigned target, w_val, w_eff, rows, tail, pct, n_frames;
    sb = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.pixel_bit = 1'b0;
    in_ch.last_of_frame = 1'b0;
    out_ch.ready = 1'b0;
    gaps_on = 1'b1;
    hold_request = 1'b0;
    stall_left = 0;
    cycle_count = 0;
    pixels_sent = 0;
    frames_sent = 0;
    width_writes = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reset width, zero and oversized widths, narrow full squares, empty frame
    send_pattern(16'b1, 1);
    write_width(cfg_t'(0));
    send_pattern(16'b1111, 4);
    write_width(cfg_t'(1023));
    send_pattern(16'b011, 3);
    write_width(cfg_t'(2));
    send_pattern(16'b1111, 4);
    send_pattern(16'b00, 2);
    write_width(cfg_t'(3));
    send_pattern(16'b111111111, 9);

    // Back-pressure: one result per pixel while the result side holds off
    write_width(cfg_t'(1));
    gaps_on = 1'b0;
    hold_request = 1'b1;
    for (int i = 0; i < 60; i++) send_pixel($urandom_range(0, 1), 1'b1);
    gaps_on = 1'b1;

    // Random phases: new width, then a few frames of random shape and density
    target = pixels_sent + 220;
    while (pixels_sent < target) begin
      case ($urandom_range(0, 9))
        0:       w_val = 0;
        1:       w_val = $urandom_range(513, 1023);
        2, 3, 4: w_val = $urandom_range(1, 8);
        default: w_val = $urandom_range(9, 32);
      endcase
      write_width(cfg_t'(w_val));
      w_eff = (w_val == 0) ? 1 : ((w_val > MAX_WIDTH) ? MAX_WIDTH : w_val);
      gaps_on = ($urandom_range(0, 4) != 0);
      n_frames = $urandom_range(1, 4);
      for (int unsigned f = 0; f < n_frames; f++) begin
        case ($urandom_range(0, 3))
          0:       pct = 100;
          1:       pct = 90;
          2:       pct = 60;
          default: pct = 25;
        endcase
        if (w_eff == MAX_WIDTH) begin
          rows = 0;
          tail = $urandom_range(1, 60);
        end else begin
          rows = (w_eff > 8) ? $urandom_range(1, 5) : $urandom_range(1, 12);
          tail = (w_eff > 1 && $urandom_range(0, 1)) ? $urandom_range(1, w_eff - 1) : 0;
        end
        send_frame(w_eff, rows, tail, pct);
      end
    end

    // Full width: a random partial row, then an all-ones partial row at full speed
    gaps_on = 1'b1;
    write_width(cfg_t'(512));
    send_frame(MAX_WIDTH, 0, 40, 85);
    gaps_on = 1'b0;
    send_frame(MAX_WIDTH, 0, 40, 100);
    gaps_on = 1'b1;

    drain();
    $display("covered %0d frames, %0d pixels, %0d width writes, %0d results checked",
             frames_sent, pixels_sent, width_writes, sb.squares_seen);
    $display("largest square predicted: side %0d", sb.biggest_side);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
